FILE: sv/dvrt_pkg.sv
`timescale 1ns / 1ps

package dvrt_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ENTRY = 2'd1;
    localparam logic [1:0] MODE_ROUND = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [1:0] REG_INFINITY = 2'd0;
    localparam logic [1:0] REG_REMOVE   = 2'd1;
    localparam logic [1:0] REG_SILENCE  = 2'd2;

    localparam logic [5:0] PREFIX_MAX = 6'd32;

    typedef struct packed {
        logic [31:0] net;
        logic [5:0]  pfx;
        logic [7:0]  metric;
        logic [31:0] via;
        logic        direct;
        logic        frozen;
        logic        reach;
        logic [7:0]  silent;
        logic [7:0]  fcount;
    } route_t;

    typedef struct packed {
        logic [31:0] lcl_addr;
        logic [31:0] net;
        logic [5:0]  pfx;
        logic [7:0]  cost;
    } nbr_t;

    function automatic logic [31:0] net_mask(input logic [5:0] pfx);
        logic [31:0] m;
        if (pfx >= PREFIX_MAX)
            m = 32'hFFFF_FFFF;
        else
            m = ~(32'hFFFF_FFFF >> pfx[4:0]);
        return m;
    endfunction

endpackage

FILE: sv/dvrt_in_if.sv
`timescale 1ns / 1ps

interface dvrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] sender_addr;
    logic [31:0] local_addr;
    logic [31:0] net_addr;
    logic [5:0]  prefix_len;
    logic [7:0]  dist_in;
    logic [5:0]  entry_index;

    modport source (output valid, mode, sender_addr, local_addr, net_addr, prefix_len,
                    dist_in, entry_index, input ready);
    modport sink (input valid, mode, sender_addr, local_addr, net_addr, prefix_len,
                  dist_in, entry_index, output ready);
endinterface

FILE: sv/dvrt_out_if.sv
`timescale 1ns / 1ps

interface dvrt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] route_net_out;
    logic [5:0]  route_prefix_out;
    logic [7:0]  route_dist_out;
    logic [31:0] route_via_out;
    logic        direct_out;
    logic        reachable_out;
    logic        frozen_out;

    modport source (output valid, status, route_net_out, route_prefix_out, route_dist_out,
                    route_via_out, direct_out, reachable_out, frozen_out, input ready);
    modport sink (input valid, status, route_net_out, route_prefix_out, route_dist_out,
                  route_via_out, direct_out, reachable_out, frozen_out, output ready);
endinterface

FILE: sv/dvrt_ram.sv
`timescale 1ns / 1ps

module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/distance_vector_route_table_top.sv
`timescale 1ns / 1ps

// Distance-vector route table. One request transfer on in_ch selects a mode:
// load a neighbour, apply one received vector entry, end a round, or read an
// entry. Every request gives exactly one result transfer on out_ch with a status
// and, for a successful read, the route fields (all zero otherwise).
// Routes live in one RAM and neighbours in another, both with a registered read.
// Each table entry visited takes a read state, then a compare and write-back state.
// A vector entry scans the neighbours, then the routes for a silent direct net to
// revive (with a second neighbour scan for its cost), then the routes for a match.
// A round end ages every route, purges the routes through each net found dead this
// round, then compacts the table.
// A new request is taken once the previous one is finished; the result sits in
// an output register, so a stalled receiver only holds the next result back.
// Reset empties both tables at once (no clearing pass) and loads the register
// defaults: infinity 16, remove rounds 5, silence rounds 3.
// The APB port writes and reads the three registers at byte addresses 0, 4, 8;
// write them only while no request is in progress.
module distance_vector_route_table_top #(
    parameter int ROUTES     = 64,
    parameter int NEIGHBOURS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    dvrt_in_if.sink     in_ch,
    dvrt_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW  = $clog2(ROUTES);
    localparam int CW  = $clog2(ROUTES + 1);
    localparam int NW  = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int NCW = $clog2(NEIGHBOURS + 1);
    localparam int IXW = (CW > 6) ? CW : 6;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_NB_RD, S_NB_EX, S_RV_RD, S_RV_EX, S_RV_WR,
        S_MS_RD, S_MS_EX, S_A_RD, S_A_EX, S_P_RD, S_P_EX, S_B_RD, S_B_EX,
        S_RQ_RD, S_RQ_EX, S_FIN
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     route_count_reg;
    logic [NCW-1:0]    nbr_count_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     w_reg;
    logic [NCW-1:0]    k_reg;
    logic [7:0]        inf_reg;
    logic [7:0]        rem_reg;
    logic [7:0]        sil_reg;

    logic [1:0]        mode_reg;
    logic [31:0]       sender_reg;
    logic [31:0]       local_reg;
    logic [31:0]       net_reg;
    logic [5:0]        pfx_reg;
    logic [7:0]        d_reg;
    logic [5:0]        idx_reg;
    logic [7:0]        cost_reg;
    logic [31:0]       nkey_reg;
    logic              nb_rv_reg;
    dvrt_pkg::route_t  cur_reg;
    dvrt_pkg::route_t  res_reg;
    logic              show_reg;
    logic [1:0]        st_reg;

    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    dvrt_pkg::route_t  out_entry_reg;

    // RAM ports
    logic                      route_we;
    logic [RW-1:0]             route_waddr;
    dvrt_pkg::route_t          route_wdata;
    logic [RW-1:0]             route_raddr;
    logic [$bits(dvrt_pkg::route_t)-1:0] route_rdata;
    logic                      nbr_we;
    dvrt_pkg::nbr_t            nbr_wdata;
    logic [$bits(dvrt_pkg::nbr_t)-1:0] nbr_rdata;

    dvrt_pkg::route_t  rrd;
    dvrt_pkg::nbr_t    nrd;
    logic              i_end;
    logic              j_end;
    logic              k_end;
    logic              tables_full;
    logic              nb_hit;
    logic              rv_hit;
    logic              ms_hit;
    logic              a_dead;
    logic              a_skip;
    logic              p_hit;
    logic              b_keep;
    logic              idx_ok;
    logic [8:0]        sum9;
    logic [7:0]        nd;
    logic              cfg_wr;
    logic [5:0]        pfx_in;

    dvrt_ram #(
        .WIDTH($bits(dvrt_pkg::route_t)),
        .DEPTH(ROUTES)
    ) u_route_ram (
        .clk     (clk),
        .wr_en   (route_we),
        .wr_addr (route_waddr),
        .wr_data (route_wdata),
        .rd_addr (route_raddr),
        .rd_data (route_rdata)
    );

    dvrt_ram #(
        .WIDTH($bits(dvrt_pkg::nbr_t)),
        .DEPTH(NEIGHBOURS)
    ) u_nbr_ram (
        .clk     (clk),
        .wr_en   (nbr_we),
        .wr_addr (nbr_count_reg[NW-1:0]),
        .wr_data (nbr_wdata),
        .rd_addr (k_reg[NW-1:0]),
        .rd_data (nbr_rdata)
    );

    assign rrd = dvrt_pkg::route_t'(route_rdata);
    assign nrd = dvrt_pkg::nbr_t'(nbr_rdata);

    assign i_end       = (i_reg >= route_count_reg);
    assign j_end       = (j_reg >= route_count_reg);
    assign k_end       = (k_reg >= nbr_count_reg);
    assign tables_full = (route_count_reg == CW'(ROUTES));
    assign idx_ok      = (IXW'(idx_reg) < IXW'(route_count_reg));
    assign pfx_in      = (in_ch.prefix_len > dvrt_pkg::PREFIX_MAX) ? dvrt_pkg::PREFIX_MAX
                                                                   : in_ch.prefix_len;

    assign nb_hit = ((nkey_reg & dvrt_pkg::net_mask(nrd.pfx)) == nrd.net)
                    && (nkey_reg != nrd.lcl_addr);
    assign rv_hit = rrd.direct && !rrd.reach
                    && ((sender_reg & dvrt_pkg::net_mask(rrd.pfx)) == rrd.net);
    assign ms_hit = (rrd.net == net_reg);
    assign a_skip = !rrd.direct || (rrd.fcount > rem_reg);
    assign a_dead = !a_skip && !rrd.reach && (rrd.silent > sil_reg);
    assign p_hit  = (rrd.net == cur_reg.net)
                    || ((rrd.via & dvrt_pkg::net_mask(cur_reg.pfx)) == cur_reg.net);
    assign b_keep = !(rrd.frozen && (rrd.fcount >= rem_reg) && !rrd.direct);

    // Distance of the advertised route after adding the sender's link cost.
    assign sum9 = {1'b0, d_reg} + {1'b0, cost_reg};
    always_comb
    begin
        if (d_reg >= inf_reg)
            nd = d_reg;
        else if (sum9 > {1'b0, inf_reg})
            nd = inf_reg;
        else
            nd = sum9[7:0];
    end

    always_comb
    begin
        route_we    = 1'b0;
        route_waddr = i_reg[RW-1:0];
        route_wdata = rrd;
        route_raddr = i_reg[RW-1:0];
        nbr_we      = 1'b0;
        nbr_wdata   = '{lcl_addr: local_reg, net: net_reg, pfx: pfx_reg, cost: d_reg};
        case (state_reg)
            S_LOAD:
            begin
                if (!tables_full && (nbr_count_reg != NCW'(NEIGHBOURS)))
                begin
                    nbr_we      = 1'b1;
                    route_we    = 1'b1;
                    route_waddr = route_count_reg[RW-1:0];
                    route_wdata = '{net: net_reg, pfx: pfx_reg, metric: d_reg, via: 32'd0,
                                    direct: 1'b1, frozen: 1'b0, reach: 1'b1,
                                    silent: 8'd0, fcount: 8'd0};
                end
            end
            S_RV_WR:
            begin
                route_we    = 1'b1;
                route_wdata = cur_reg;
            end
            S_MS_RD:
            begin
                if (i_end && (nd < inf_reg) && !tables_full)
                begin
                    route_we    = 1'b1;
                    route_waddr = route_count_reg[RW-1:0];
                    route_wdata = '{net: net_reg, pfx: pfx_reg, metric: nd, via: sender_reg,
                                    direct: 1'b0, frozen: 1'b0, reach: 1'b0,
                                    silent: 8'd0, fcount: 8'd0};
                end
            end
            S_MS_EX:
            begin
                if (ms_hit && !rrd.frozen)
                begin
                    route_we = 1'b1;
                    if ((nd == inf_reg) && (rrd.via == sender_reg))
                    begin
                        route_wdata.frozen = 1'b1;
                        route_wdata.fcount = 8'd0;
                        route_wdata.metric = inf_reg;
                    end
                    if (nd < route_wdata.metric)
                    begin
                        route_wdata.metric = nd;
                        route_wdata.via    = sender_reg;
                    end
                end
            end
            S_A_EX:
            begin
                if (!a_skip)
                begin
                    route_we = 1'b1;
                    if (rrd.reach)
                        route_wdata.reach = 1'b0;
                    else if (!a_dead)
                        route_wdata.silent = (rrd.silent == 8'hFF) ? 8'hFF
                                                                   : rrd.silent + 8'd1;
                    else
                    begin
                        route_wdata.metric = inf_reg;
                        route_wdata.frozen = 1'b1;
                    end
                end
            end
            S_P_RD:
            begin
                route_raddr = j_reg[RW-1:0];
            end
            S_P_EX:
            begin
                route_waddr = j_reg[RW-1:0];
                if (p_hit)
                begin
                    route_we           = 1'b1;
                    route_wdata.frozen = 1'b1;
                    route_wdata.metric = inf_reg;
                end
            end
            S_B_EX:
            begin
                route_waddr = w_reg[RW-1:0];
                route_we    = b_keep;
                if (rrd.frozen)
                begin
                    if (rrd.fcount >= rem_reg)
                        route_wdata.frozen = 1'b0;
                    else
                        route_wdata.fcount = rrd.fcount + 8'd1;
                end
            end
            S_RQ_RD:
            begin
                route_raddr = RW'(idx_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            dvrt_pkg::REG_INFINITY: prdata = {24'd0, inf_reg};
            dvrt_pkg::REG_REMOVE:   prdata = {24'd0, rem_reg};
            dvrt_pkg::REG_SILENCE:  prdata = {24'd0, sil_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            route_count_reg <= '0;
            nbr_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
            inf_reg         <= 8'd16;
            rem_reg         <= 8'd5;
            sil_reg         <= 8'd3;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    dvrt_pkg::REG_INFINITY: inf_reg <= pwdata[7:0];
                    dvrt_pkg::REG_REMOVE:   rem_reg <= pwdata[7:0];
                    dvrt_pkg::REG_SILENCE:  sil_reg <= pwdata[7:0];
                    default:
                    begin
                    end
                endcase
            end
            // In S_FIN a finished transfer is replaced by the next result directly.
            if (out_valid_reg && out_ch.ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        mode_reg   <= in_ch.mode;
                        sender_reg <= in_ch.sender_addr;
                        local_reg  <= in_ch.local_addr;
                        net_reg    <= in_ch.net_addr & dvrt_pkg::net_mask(pfx_in);
                        pfx_reg    <= pfx_in;
                        d_reg      <= in_ch.dist_in;
                        idx_reg    <= in_ch.entry_index;
                        show_reg   <= 1'b0;
                        i_reg      <= '0;
                        k_reg      <= '0;
                        nkey_reg   <= in_ch.sender_addr;
                        nb_rv_reg  <= 1'b0;
                        case (in_ch.mode)
                            dvrt_pkg::MODE_LOAD:  state_reg <= S_LOAD;
                            dvrt_pkg::MODE_ENTRY: state_reg <= S_NB_RD;
                            dvrt_pkg::MODE_ROUND: state_reg <= S_A_RD;
                            default:              state_reg <= S_RQ_RD;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (tables_full || (nbr_count_reg == NCW'(NEIGHBOURS)))
                        st_reg <= dvrt_pkg::ST_FULL;
                    else
                    begin
                        st_reg          <= dvrt_pkg::ST_DONE;
                        nbr_count_reg   <= nbr_count_reg + NCW'(1);
                        route_count_reg <= route_count_reg + CW'(1);
                    end
                    state_reg <= S_FIN;
                end
                S_NB_RD:
                begin
                    if (k_end)
                    begin
                        if (nb_rv_reg)
                            state_reg <= S_RV_WR;
                        else
                        begin
                            st_reg    <= dvrt_pkg::ST_IGNORED;
                            state_reg <= S_FIN;
                        end
                    end
                    else
                        state_reg <= S_NB_EX;
                end
                S_NB_EX:
                begin
                    if (nb_hit)
                    begin
                        if (nb_rv_reg)
                        begin
                            cur_reg.metric <= nrd.cost;
                            state_reg      <= S_RV_WR;
                        end
                        else
                        begin
                            cost_reg  <= nrd.cost;
                            i_reg     <= '0;
                            state_reg <= S_RV_RD;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + NCW'(1);
                        state_reg <= S_NB_RD;
                    end
                end
                S_RV_RD:
                begin
                    if (i_end)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_MS_RD;
                    end
                    else
                        state_reg <= S_RV_EX;
                end
                S_RV_EX:
                begin
                    if (rv_hit)
                    begin
                        // Revive the first silent direct net holding the sender, then
                        // look up its link cost among the neighbours.
                        cur_reg   <= '{net: rrd.net, pfx: rrd.pfx, metric: rrd.metric,
                                       via: rrd.via, direct: rrd.direct, frozen: 1'b0,
                                       reach: 1'b1, silent: 8'd0, fcount: 8'd0};
                        nkey_reg  <= rrd.net;
                        k_reg     <= '0;
                        nb_rv_reg <= 1'b1;
                        state_reg <= S_NB_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_RV_RD;
                    end
                end
                S_RV_WR:
                begin
                    i_reg     <= '0;
                    state_reg <= S_MS_RD;
                end
                S_MS_RD:
                begin
                    if (i_end)
                    begin
                        if (nd >= inf_reg)
                            st_reg <= dvrt_pkg::ST_IGNORED;
                        else if (tables_full)
                            st_reg <= dvrt_pkg::ST_FULL;
                        else
                        begin
                            st_reg          <= dvrt_pkg::ST_DONE;
                            route_count_reg <= route_count_reg + CW'(1);
                        end
                        state_reg <= S_FIN;
                    end
                    else
                        state_reg <= S_MS_EX;
                end
                S_MS_EX:
                begin
                    if (ms_hit)
                    begin
                        st_reg    <= rrd.frozen ? dvrt_pkg::ST_IGNORED : dvrt_pkg::ST_DONE;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_MS_RD;
                    end
                end
                S_A_RD:
                begin
                    if (i_end)
                    begin
                        i_reg     <= '0;
                        w_reg     <= '0;
                        state_reg <= S_B_RD;
                    end
                    else
                        state_reg <= S_A_EX;
                end
                S_A_EX:
                begin
                    if (a_dead)
                    begin
                        cur_reg   <= rrd;
                        j_reg     <= '0;
                        state_reg <= S_P_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_A_RD;
                    end
                end
                S_P_RD:
                begin
                    if (j_end)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_A_RD;
                    end
                    else
                        state_reg <= S_P_EX;
                end
                S_P_EX:
                begin
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= S_P_RD;
                end
                S_B_RD:
                begin
                    // Compaction: kept entries are copied down to the write index.
                    if (i_end)
                    begin
                        route_count_reg <= w_reg;
                        st_reg          <= dvrt_pkg::ST_DONE;
                        state_reg       <= S_FIN;
                    end
                    else
                        state_reg <= S_B_EX;
                end
                S_B_EX:
                begin
                    if (b_keep)
                        w_reg <= w_reg + CW'(1);
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_B_RD;
                end
                S_RQ_RD:
                begin
                    if (idx_ok)
                        state_reg <= S_RQ_EX;
                    else
                    begin
                        st_reg    <= dvrt_pkg::ST_INVALID;
                        state_reg <= S_FIN;
                    end
                end
                S_RQ_EX:
                begin
                    res_reg   <= rrd;
                    show_reg  <= 1'b1;
                    st_reg    <= dvrt_pkg::ST_DONE;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= st_reg;
                        out_entry_reg  <= show_reg ? res_reg : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready             = (state_reg == S_IDLE);
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = out_status_reg;
    assign out_ch.route_net_out    = out_entry_reg.net;
    assign out_ch.route_prefix_out = out_entry_reg.pfx;
    assign out_ch.route_dist_out   = out_entry_reg.metric;
    assign out_ch.route_via_out    = out_entry_reg.via;
    assign out_ch.direct_out       = out_entry_reg.direct;
    assign out_ch.reachable_out    = out_entry_reg.reach;
    assign out_ch.frozen_out       = out_entry_reg.frozen;

`ifndef SYNTHESIS
    a_route_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        route_count_reg <= CW'(ROUTES))
        else $error("route count beyond table size");

    a_nbr_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nbr_count_reg <= NCW'(NEIGHBOURS))
        else $error("neighbour count beyond table size");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_B_RD) |-> (w_reg <= i_reg))
        else $error("compaction write index passed read index");

    a_mode_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_FIN) |=> $stable(mode_reg))
        else $error("request changed while in progress");
`endif

endmodule
